>>> rtl/core/cbe_pkg.sv
// shared constants, types and constant functions of the crystal ball evaluator
// used by every module under rtl/core; no dependencies
package cbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int XB        = 28;                 // fraction bits of logs and exponents

  localparam int AMP_W   = 48;
  localparam int MEAN_W  = 32;
  localparam int WID_W   = 32;
  localparam int CUT_W   = 24;
  localparam int CFG_W   = 48;
  localparam int NUM_W   = MEAN_W + 1 + FRAC_BITS;  // dividend and quotient width
  localparam int U_W     = 39;
  localparam int LOG_W   = 6 + XB;
  localparam int HB_W    = 36;
  localparam int ND_W    = CUT_W + LOG_W;
  localparam int E_W     = 64;
  localparam int EI_W    = E_W - XB;
  localparam int P_W     = 31;                   // scale factor, q1.30

  localparam int DIV_LAT   = NUM_W;
  localparam int LOG_LAT   = XB + 2;
  localparam int SCALE_LAT = XB + 2;

  localparam int HSQ_SH = 2 * FRAC_BITS + 1 - XB;
  localparam logic [28:0] LOG2E_Q = 29'd387270501;
  localparam logic [63:0] H_CAP   = 64'd64 << XB;
  localparam logic [U_W-1:0] U_MAX = '1;
  localparam logic [CUT_W-1:0] CUT_MAX = '1;

  typedef enum logic [1:0] {
    REG_LOW  = 2'd0,
    REG_CORE = 2'd1,
    REG_HIGH = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    CFG_AMPLITUDE  = 3'd0,
    CFG_PEAK_MEAN  = 3'd1,
    CFG_CORE_WIDTH = 3'd2,
    CFG_LOW_CUT    = 3'd3,
    CFG_LOW_POWER  = 3'd4,
    CFG_HIGH_CUT   = 3'd5,
    CFG_HIGH_POWER = 3'd6
  } cfg_idx_e;

  // integer square root, bit by bit
  function automatic logic [63:0] cbe_isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] bt;
    r   = '0;
    rem = v;
    for (int i = 31; i >= 0; i--) begin
      bt = 64'd1 << (2 * i);
      if (rem >= r + bt) begin
        rem = rem - (r + bt);
        r   = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // 2^-(2^-idx) in q0.30, by repeated roots of one half
  function automatic logic [29:0] cbe_root(input int idx);
    logic [63:0] r;
    r = cbe_isqrt(64'd1 << 59);
    for (int i = 1; i < idx; i++) begin
      r = cbe_isqrt(r << 30);
    end
    return r[29:0];
  endfunction

endpackage

>>> rtl/core/cbe_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on cbe_pkg
module cbe_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cbe_pkg::NUM_W-1:0]  num_i,
  input  logic [cbe_pkg::WID_W-1:0]  den_i,
  output logic [cbe_pkg::NUM_W-1:0]  quo_o
);
  import cbe_pkg::*;

  logic [WID_W-1:0] rem_q [DIV_LAT];
  logic [NUM_W-1:0] nq_q  [DIV_LAT];  // dividend bits shift out, quotient bits shift in

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
    logic [WID_W-1:0] rem_in;
    logic [NUM_W-1:0] nq_in;
    logic [WID_W:0]   trial;
    logic [WID_W:0]   diff;
    logic             take;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
    end
    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den_i};
    assign take  = trial >= {1'b0, den_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? diff[WID_W-1:0] : trial[WID_W-1:0];
        nq_q[s]  <= {nq_in[NUM_W-2:0], take};
      end
    end
  end

  assign quo_o = nq_q[DIV_LAT-1];

endmodule

>>> rtl/core/cbe_log2.sv
// pipelined base-2 logarithm: leading one search, normalize, then one squaring per stage
// depends on cbe_pkg
module cbe_log2 (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [63:0]                val_i,
  output logic [cbe_pkg::LOG_W-1:0]  log_o
);
  import cbe_pkg::*;

  logic [63:0] v_q;
  logic [5:0]  ka_q;
  logic [5:0]  kb_q;
  logic [30:0] mb_q;
  logic [5:0]  k_lead;
  logic [95:0] norm;

  logic [30:0]   m_q [XB];
  logic [XB-1:0] f_q [XB];
  logic [5:0]    k_q [XB];

  always_comb begin
    k_lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (val_i[i]) k_lead = 6'(i);
    end
  end

  assign norm = (96'(v_q) << 30) >> ka_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q  <= val_i;
      ka_q <= k_lead;
      mb_q <= norm[30:0];
      kb_q <= ka_q;
    end
  end

  for (genvar g = 0; g < XB; g++) begin : g_sq
    logic [30:0]   m_in;
    logic [XB-1:0] f_in;
    logic [5:0]    k_in;
    logic [61:0]   sq;
    logic          hi;
    if (g == 0) begin : g_first
      assign m_in = mb_q;
      assign f_in = '0;
      assign k_in = kb_q;
    end else begin : g_next
      assign m_in = m_q[g-1];
      assign f_in = f_q[g-1];
      assign k_in = k_q[g-1];
    end
    assign sq = 62'(m_in) * 62'(m_in);
    assign hi = sq[61];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[g] <= hi ? sq[61:31] : sq[60:30];
        f_q[g] <= {f_in[XB-2:0], hi};
        k_q[g] <= k_in;
      end
    end
  end

  assign log_o = {k_q[XB-1], f_q[XB-1]};

endmodule

>>> rtl/core/cbe_scale.sv
// pipelined amplitude * 2^-e: one root factor per stage, then product and final shift
// depends on cbe_pkg
module cbe_scale (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [cbe_pkg::E_W-1:0]   e_i,
  input  logic [cbe_pkg::AMP_W-1:0] amp_i,
  output logic [cbe_pkg::AMP_W-1:0] value_o,
  output logic                      sat_o
);
  import cbe_pkg::*;

  logic [P_W-1:0]  p_q  [XB];
  logic [XB-1:0]   ef_q [XB];
  logic [EI_W-1:0] ei_q [XB];

  for (genvar g = 0; g < XB; g++) begin : g_fac
    localparam logic [29:0] ROOT = cbe_root(g + 1);
    logic [P_W-1:0]  p_in;
    logic [XB-1:0]   ef_in;
    logic [EI_W-1:0] ei_in;
    logic [60:0]     prod;
    if (g == 0) begin : g_first
      assign p_in  = P_W'(1) << 30;
      assign ef_in = e_i[XB-1:0];
      assign ei_in = e_i[E_W-1:XB];
    end else begin : g_next
      assign p_in  = p_q[g-1];
      assign ef_in = ef_q[g-1];
      assign ei_in = ei_q[g-1];
    end
    assign prod = 61'(p_in) * 61'(ROOT);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[g]  <= ef_in[XB-1-g] ? prod[60:30] : p_in;
        ef_q[g] <= ef_in;
        ei_q[g] <= ei_in;
      end
    end
  end

  logic [54:0]     hi_q;
  logic [54:0]     lo_q;
  logic [EI_W-1:0] eih_q;
  logic [55:0]     sum;
  logic [55:0]     res;
  logic [6:0]      sh;
  logic            big;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q  <= 55'(amp_i[47:24]) * 55'(p_q[XB-1]);
      lo_q  <= 55'(amp_i[23:0]) * 55'(p_q[XB-1]);
      eih_q <= ei_q[XB-1];
    end
  end

  assign big = eih_q >= EI_W'(49);
  assign sum = 56'(hi_q) + 56'(lo_q >> 24);
  assign sh  = 7'(eih_q[5:0]) + 7'd6;
  assign res = sum >> sh;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (big) begin
        value_o <= '0;
        sat_o   <= 1'b0;
      end else if (res[55:48] != '0) begin
        value_o <= '1;
        sat_o   <= 1'b1;
      end else begin
        value_o <= res[47:0];
        sat_o   <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/double_crystal_ball_eval.sv
// top level of the double-sided crystal ball evaluator: config registers, offset,
// region select, tail log terms and scaling; depends on cbe_pkg, cbe_div, cbe_log2, cbe_scale
//
// Evaluates the double-sided crystal ball shape at one abscissa per word, in fixed
// point with 16 fraction bits. A word enters every cycle unless the output stalls.
// The pipeline depth is set by the restoring divider for t = (x - mean) / sigma
// (one quotient bit per stage), the two log2 units (one squaring multiply per
// stage) and the scaler (one root factor of 2^-frac per stage). The whole pipeline
// advances together: it moves whenever the output register is empty or being
// taken, so s_axis_tready follows m_axis_tready while a result waits. Config
// writes must only happen while the pipeline holds no word, since the stages read
// the registers live. Region is 0 for the low tail, 1 for the core and 2 for the
// high tail; the saturated flag marks a value clipped to all ones.
module double_crystal_ball_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [cbe_pkg::CFG_W-1:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] abscissa
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] value
  output logic [2:0]  m_axis_tuser    // [1:0] region, [2] saturated
);
  import cbe_pkg::*;

  localparam int N_DLY   = LOG_LAT + 3;
  localparam int HB_DLY  = LOG_LAT + 1;
  localparam int REG_DLY = LOG_LAT + 5 + SCALE_LAT;
  localparam int LAT     = 2 + DIV_LAT + REG_DLY;

  // config registers
  logic [AMP_W-1:0]  amplitude_q;
  logic [MEAN_W-1:0] peak_mean_q;
  logic [WID_W-1:0]  core_width_q;
  logic [CUT_W-1:0]  low_cut_q, low_power_q, high_cut_q, high_power_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q  <= AMP_W'(1) << FRAC_BITS;
      peak_mean_q  <= '0;
      core_width_q <= WID_W'(1) << FRAC_BITS;
      low_cut_q    <= CUT_W'(1) << FRAC_BITS;
      low_power_q  <= CUT_W'(26214);
      high_cut_q   <= CUT_W'(1) << FRAC_BITS;
      high_power_q <= CUT_W'(4) << FRAC_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AMPLITUDE:  amplitude_q  <= cfg_data_i[AMP_W-1:0];
        CFG_PEAK_MEAN:  peak_mean_q  <= cfg_data_i[MEAN_W-1:0];
        CFG_CORE_WIDTH: core_width_q <= cfg_data_i[WID_W-1:0];
        CFG_LOW_CUT:    low_cut_q    <= cfg_data_i[CUT_W-1:0];
        CFG_LOW_POWER:  low_power_q  <= cfg_data_i[CUT_W-1:0];
        CFG_HIGH_CUT:   high_cut_q   <= cfg_data_i[CUT_W-1:0];
        CFG_HIGH_POWER: high_power_q <= cfg_data_i[CUT_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // global advance: the pipeline moves when the output register can take a word
  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // zero register values stand for one lsb
  logic [WID_W-1:0] den;
  logic [CUT_W-1:0] alo, ahi, nlo, nhi;
  assign den = (core_width_q == '0) ? WID_W'(1) : core_width_q;
  assign alo = (low_cut_q    == '0) ? CUT_W'(1) : low_cut_q;
  assign ahi = (high_cut_q   == '0) ? CUT_W'(1) : high_cut_q;
  assign nlo = (low_power_q  == '0) ? CUT_W'(1) : low_power_q;
  assign nhi = (high_power_q == '0) ? CUT_W'(1) : high_power_q;

  // offset from the mean, sign and magnitude
  logic [MEAN_W:0]  diff;
  logic [MEAN_W:0]  mag;
  logic [NUM_W-1:0] num_q;
  logic             sgn_q;

  assign diff = {s_axis_tdata[31], s_axis_tdata} - {peak_mean_q[MEAN_W-1], peak_mean_q};
  assign mag  = diff[MEAN_W] ? -diff : diff;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q <= {mag, {FRAC_BITS{1'b0}}};
      sgn_q <= diff[MEAN_W];
    end
  end

  logic [NUM_W-1:0] tmag;
  logic             sgn_dly [DIV_LAT];

  cbe_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_q),
    .den_i (den),
    .quo_o (tmag)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgn_dly[0] <= sgn_q;
      for (int i = 1; i < DIV_LAT; i++) sgn_dly[i] <= sgn_dly[i-1];
    end
  end

  // region select, tail distance and half-square operand
  logic             neg, is_low, is_core;
  logic [CUT_W-1:0] a_sel, n_sel;
  logic [NUM_W-1:0] udiff, hsq_in;
  region_e          reg_sel;

  assign neg     = sgn_dly[DIV_LAT-1] && (tmag != '0);
  assign is_low  = neg && (tmag > NUM_W'(alo));
  assign is_core = !is_low && (neg || (tmag < NUM_W'(ahi)));
  assign a_sel   = is_low ? alo : ahi;
  assign n_sel   = is_low ? nlo : nhi;
  assign udiff   = tmag - NUM_W'(a_sel);
  assign hsq_in  = is_core ? tmag : NUM_W'(a_sel);

  always_comb begin
    priority if (is_low) reg_sel = REG_LOW;
    else if (is_core)    reg_sel = REG_CORE;
    else                 reg_sel = REG_HIGH;
  end

  logic [U_W-1:0]   r_u_q;
  logic [CUT_W-1:0] r_a_q, r_n_q, r_mc_q;
  region_e          r_reg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_u_q   <= (udiff > NUM_W'(U_MAX)) ? U_MAX : udiff[U_W-1:0];
      r_a_q   <= a_sel;
      r_n_q   <= n_sel;
      r_mc_q  <= (hsq_in > NUM_W'(CUT_MAX)) ? CUT_MAX : hsq_in[CUT_W-1:0];
      r_reg_q <= reg_sel;
    end
  end

  // tail arguments n0 = n << frac and n1 = n0 + u*a, and the half square
  logic [62:0] prod_q;
  logic [63:0] n0_q, n0b_q, n1_q;
  logic [47:0] sq_q;
  logic [63:0] hs;
  logic [34:0] h_q;
  logic [HB_W-1:0] hb_q;
  logic [63:0] hb_full;

  if (HSQ_SH >= 0) begin : g_hsq_right
    assign hs = 64'(sq_q) >> HSQ_SH;
  end else begin : g_hsq_left
    assign hs = 64'(sq_q) << (-HSQ_SH);
  end

  assign hb_full = 64'(h_q) * 64'(LOG2E_Q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= 63'(r_u_q) * 63'(r_a_q);
      n0_q   <= 64'(r_n_q) << FRAC_BITS;
      sq_q   <= 48'(r_mc_q) * 48'(r_mc_q);
      n1_q   <= n0_q + 64'(prod_q);
      n0b_q  <= n0_q;
      h_q    <= (hs > H_CAP) ? H_CAP[34:0] : hs[34:0];
      hb_q   <= HB_W'(hb_full >> XB);
    end
  end

  logic [LOG_W-1:0] l0, l1;

  cbe_log2 u_log_n0 (
    .clk_i (clk_i),
    .en_i  (adv),
    .val_i (n0b_q),
    .log_o (l0)
  );

  cbe_log2 u_log_n1 (
    .clk_i (clk_i),
    .en_i  (adv),
    .val_i (n1_q),
    .log_o (l1)
  );

  // side data delayed to meet the log results
  logic [CUT_W-1:0] n_dly   [N_DLY];
  logic [HB_W-1:0]  hb_dly  [HB_DLY];
  region_e          reg_dly [REG_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_dly[0]   <= r_n_q;
      hb_dly[0]  <= hb_q;
      reg_dly[0] <= r_reg_q;
      for (int i = 1; i < N_DLY; i++)   n_dly[i]   <= n_dly[i-1];
      for (int i = 1; i < HB_DLY; i++)  hb_dly[i]  <= hb_dly[i-1];
      for (int i = 1; i < REG_DLY; i++) reg_dly[i] <= reg_dly[i-1];
    end
  end

  // tail term n * (log2 n1 - log2 n0) >> frac, then total exponent in bits
  logic [LOG_W-1:0] d_q;
  logic [ND_W-1:0]  nd_q;
  logic [E_W-1:0]   e_q;
  logic             tail_e;

  assign tail_e = reg_dly[LOG_LAT+3] != REG_CORE;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q  <= (l1 > l0) ? (l1 - l0) : '0;
      nd_q <= ND_W'(n_dly[N_DLY-1]) * ND_W'(d_q);
      e_q  <= E_W'(hb_dly[HB_DLY-1]) + (tail_e ? E_W'(nd_q >> FRAC_BITS) : '0);
    end
  end

  logic [AMP_W-1:0] value;
  logic             sat;

  cbe_scale u_scale (
    .clk_i   (clk_i),
    .en_i    (adv),
    .e_i     (e_q),
    .amp_i   (amplitude_q),
    .value_o (value),
    .sat_o   (sat)
  );

  assign m_axis_tdata = value;
  assign m_axis_tuser = {sat, reg_dly[REG_DLY-1]};

endmodule

>>> rtl/core/cbe_checker.sv
// port-level checks of the crystal ball evaluator, bound to the top level
// depends on double_crystal_ball_eval and cbe_pkg
module cbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import cbe_pkg::*;

  // whole pipeline stalls only behind an unread result
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_region_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
    else $error("unused region code on output");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == 48'hFFFF_FFFF_FFFF))
    else $error("saturated flag without clipped value");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output word changed while stalled");

endmodule

bind double_crystal_ball_eval cbe_checker u_cbe_checker (.*);
